>>> rtl/dshtlm_pkg.sv
// shared types, widths and constants for the dshot telemetry rpm decoder
// no dependencies; used by dshtlm_div and dshot_telemetry_rpm_decoder_unit
`default_nettype none

package dshtlm_pkg;

  localparam int unsigned RAW_W      = 21;
  localparam int unsigned S_TDATA_W  = 24;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned RPM_W      = 26;
  localparam int unsigned M_TDATA_W  = 32;
  localparam int unsigned POLE_W     = 8;
  localparam int unsigned GCR_W      = 5;
  localparam int unsigned NIB_W      = 4;
  localparam int unsigned GROUPS     = 4;
  localparam int unsigned PAYLOAD_W  = 12;
  localparam int unsigned MANT_W     = 9;
  localparam int unsigned EXP_W      = 3;

  // divider operand widths: dividend covers 2 * 60000000, divisor covers the mantissa
  localparam int unsigned NUM_W      = 27;
  localparam int unsigned DEN_W      = 9;

  localparam logic [NUM_W-1:0]     ERPM_SCALE    = 27'd60000000;
  localparam logic [POLE_W-1:0]    POLES_RESET   = 8'd14;
  localparam logic [POLE_W-1:0]    POLES_MIN     = 8'd2;
  localparam logic [PAYLOAD_W-1:0] ZERO_RPM_CODE = 12'hFFF;
  localparam logic [RPM_W-1:0]     RPM_MAX       = 26'd60000000;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_GCR_ERR     = 2'd1,
    ST_CRC_ERR     = 2'd2,
    ST_ZERO_PERIOD = 2'd3
  } status_e;

  // carried alongside the divider pipelines
  typedef struct packed {
    status_e          status;
    logic             zero_rpm;
    logic [EXP_W-1:0] exponent;
  } side_t;

  // gcr symbol to nibble, msb set marks an invalid symbol
  function automatic logic [NIB_W:0] gcr_lookup(input logic [GCR_W-1:0] sym);
    logic [NIB_W:0] res;
    unique case (sym)
      5'h09:   res = {1'b0, 4'h9};
      5'h0A:   res = {1'b0, 4'hA};
      5'h0B:   res = {1'b0, 4'hB};
      5'h0D:   res = {1'b0, 4'hD};
      5'h0E:   res = {1'b0, 4'hE};
      5'h0F:   res = {1'b0, 4'hF};
      5'h12:   res = {1'b0, 4'h2};
      5'h13:   res = {1'b0, 4'h3};
      5'h15:   res = {1'b0, 4'h5};
      5'h16:   res = {1'b0, 4'h6};
      5'h17:   res = {1'b0, 4'h7};
      5'h19:   res = {1'b0, 4'h0};
      5'h1A:   res = {1'b0, 4'h8};
      5'h1B:   res = {1'b0, 4'h1};
      5'h1D:   res = {1'b0, 4'h4};
      5'h1E:   res = {1'b0, 4'hC};
      default: res = {1'b1, 4'h0};
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

>>> rtl/dshot_telemetry_rpm_decoder_unit.sv
// path from an input transfer to the output stream: decode, check, erpm divider, rescale, pole divider, output register
// throughput: one telemetry word per cycle; every stage advances together, and
// the whole pipeline holds only while the output register is full and not taken
// the two 27-stage bit-per-stage dividers (erpm, then pole scaling) set the depth
// reset: valid bits cleared, pole count returns to 14; no clearing pass
// depends on dshtlm_pkg and dshtlm_div
`default_nettype none

module dshot_telemetry_rpm_decoder_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [dshtlm_pkg::POLE_W-1:0]      cfg_wdata_i,   // pole_count
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [dshtlm_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // [20:0] raw_word
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [dshtlm_pkg::M_TDATA_W-1:0]   m_axis_tdata   // [1:0] status, [27:2] rpm
);

  localparam int unsigned RAW_W  = dshtlm_pkg::RAW_W;
  localparam int unsigned NUM_W  = dshtlm_pkg::NUM_W;
  localparam int unsigned DEN_W  = dshtlm_pkg::DEN_W;
  localparam int unsigned RPM_W  = dshtlm_pkg::RPM_W;
  localparam int unsigned GCR_W  = dshtlm_pkg::GCR_W;
  localparam int unsigned NIB_W  = dshtlm_pkg::NIB_W;
  localparam int unsigned GROUPS = dshtlm_pkg::GROUPS;
  localparam int unsigned MANT_W = dshtlm_pkg::MANT_W;
  localparam int unsigned PAY_W  = dshtlm_pkg::PAYLOAD_W;
  localparam int unsigned POLE_W = dshtlm_pkg::POLE_W;

  logic                         en;
  logic [POLE_W-1:0]            pole_q;
  logic [POLE_W-1:0]            poles;

  // decode stage
  logic [RAW_W-1:0]             raw;
  logic [RAW_W-1:0]             gcr;
  logic [GROUPS*NIB_W-1:0]      a_val_d;
  logic                         a_bad_d;
  logic                         a_vld_q;
  logic [GROUPS*NIB_W-1:0]      a_val_q;
  logic                         a_bad_q;

  // check stage
  logic [PAY_W-1:0]             payload;
  logic [NIB_W-1:0]             crc;
  dshtlm_pkg::side_t            b_side_d;
  logic                         b_vld_q;
  dshtlm_pkg::side_t            b_side_q;
  logic [MANT_W-1:0]            b_man_q;

  // erpm divider and rescale stage
  logic                         d1_vld;
  logic [NUM_W-1:0]             d1_quo;
  dshtlm_pkg::side_t            d1_side;
  logic [NUM_W-1:0]             erpm;
  logic                         c_vld_q;
  logic [NUM_W-1:0]             c_num_q;
  dshtlm_pkg::side_t            c_side_q;

  // pole divider and output register
  logic                         d2_vld;
  logic [NUM_W-1:0]             d2_quo;
  dshtlm_pkg::side_t            d2_side;
  logic                         out_vld_q;
  dshtlm_pkg::status_e          out_status_q;
  logic [RPM_W-1:0]             out_rpm_q;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pole_q <= dshtlm_pkg::POLES_RESET;
    end else if (cfg_we_i) begin
      pole_q <= cfg_wdata_i;
    end
  end

  assign poles = (pole_q < dshtlm_pkg::POLES_MIN) ? dshtlm_pkg::POLES_MIN : pole_q;

  // undo transition coding and map the four gcr groups
  assign raw = s_axis_tdata[RAW_W-1:0];
  assign gcr = raw ^ (raw >> 1);

  always_comb begin
    logic [NIB_W:0] sym;
    a_val_d = '0;
    a_bad_d = 1'b0;
    for (int k = 0; k < GROUPS; k++) begin
      sym = dshtlm_pkg::gcr_lookup(gcr[k*GCR_W +: GCR_W]);
      a_val_d[k*NIB_W +: NIB_W] = sym[NIB_W-1:0];
      a_bad_d = a_bad_d | sym[NIB_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= s_axis_tvalid;
      b_vld_q <= a_vld_q;
      c_vld_q <= d1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_val_q <= a_val_d;
      a_bad_q <= a_bad_d;
    end
  end

  assign payload = a_val_q[GROUPS*NIB_W-1:NIB_W];
  assign crc     = ~(payload[3:0] ^ payload[7:4] ^ payload[11:8]);

  always_comb begin
    b_side_d.zero_rpm = 1'b0;
    b_side_d.exponent = payload[PAY_W-1:MANT_W];
    priority if (a_bad_q) begin
      b_side_d.status = dshtlm_pkg::ST_GCR_ERR;
    end else if (crc != a_val_q[NIB_W-1:0]) begin
      b_side_d.status = dshtlm_pkg::ST_CRC_ERR;
    end else if (payload == dshtlm_pkg::ZERO_RPM_CODE) begin
      b_side_d.status   = dshtlm_pkg::ST_OK;
      b_side_d.zero_rpm = 1'b1;
    end else if (payload[MANT_W-1:0] == '0) begin
      b_side_d.status = dshtlm_pkg::ST_ZERO_PERIOD;
    end else begin
      b_side_d.status = dshtlm_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_side_q <= b_side_d;
      b_man_q  <= payload[MANT_W-1:0];
    end
  end

  // 60000000 / (m << e) is (60000000 / m) >> e
  dshtlm_div u_erpm_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (b_vld_q),
    .num_i  (dshtlm_pkg::ERPM_SCALE),
    .den_i  (b_man_q),
    .side_i (b_side_q),
    .vld_o  (d1_vld),
    .quo_o  (d1_quo),
    .side_o (d1_side)
  );

  assign erpm = d1_quo >> d1_side.exponent;

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_num_q  <= {erpm[NUM_W-2:0], 1'b0};
      c_side_q <= d1_side;
    end
  end

  dshtlm_div u_pole_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (c_vld_q),
    .num_i  (c_num_q),
    .den_i  ({{(DEN_W-POLE_W){1'b0}}, poles}),
    .side_i (c_side_q),
    .vld_o  (d2_vld),
    .quo_o  (d2_quo),
    .side_o (d2_side)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= d2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_status_q <= d2_side.status;
      if (d2_side.status == dshtlm_pkg::ST_OK && !d2_side.zero_rpm) begin
        out_rpm_q <= d2_quo[RPM_W-1:0];
      end else begin
        out_rpm_q <= '0;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(dshtlm_pkg::M_TDATA_W - RPM_W - dshtlm_pkg::STATUS_W){1'b0}},
                          out_rpm_q, out_status_q};

  // error results never carry an rpm
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_status_q != dshtlm_pkg::ST_OK |-> out_rpm_q == '0)
    else $error("rpm nonzero on an error result");

  // the pole divider can never exceed the full-scale erpm
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> out_rpm_q <= dshtlm_pkg::RPM_MAX)
    else $error("rpm above full scale");

  // a zero mantissa reaching the check stage must come out flagged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && a_vld_q && !a_bad_q && crc == a_val_q[NIB_W-1:0]
      && payload != dshtlm_pkg::ZERO_RPM_CODE && payload[MANT_W-1:0] == '0
      |=> b_side_q.status == dshtlm_pkg::ST_ZERO_PERIOD)
    else $error("zero period not flagged");

endmodule

`default_nettype wire

>>> rtl/dshtlm_div.sv
// pipelined restoring divider, one quotient bit per register stage
// depends on dshtlm_pkg for operand widths and the sideband type
`default_nettype none

module dshtlm_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           vld_i,
  input  logic [dshtlm_pkg::NUM_W-1:0]   num_i,
  input  logic [dshtlm_pkg::DEN_W-1:0]   den_i,
  input  dshtlm_pkg::side_t              side_i,
  output logic                           vld_o,
  output logic [dshtlm_pkg::NUM_W-1:0]   quo_o,
  output dshtlm_pkg::side_t              side_o
);

  localparam int unsigned N = dshtlm_pkg::NUM_W;
  localparam int unsigned D = dshtlm_pkg::DEN_W;

  logic              vld_q  [N];
  logic [N-1:0]      num_q  [N];
  logic [D-1:0]      rem_q  [N];
  logic [D-1:0]      den_q  [N];
  dshtlm_pkg::side_t side_q [N];

  logic              vld_in  [N];
  logic [N-1:0]      num_in  [N];
  logic [D-1:0]      rem_in  [N];
  logic [D-1:0]      den_in  [N];
  dshtlm_pkg::side_t side_in [N];

  logic [D:0]        trial_w [N];
  logic [D:0]        diff_w  [N];
  logic              fit_w   [N];

  always_comb begin
    vld_in[0]  = vld_i;
    num_in[0]  = num_i;
    rem_in[0]  = '0;
    den_in[0]  = den_i;
    side_in[0] = side_i;
    for (int k = 1; k < N; k++) begin
      vld_in[k]  = vld_q[k-1];
      num_in[k]  = num_q[k-1];
      rem_in[k]  = rem_q[k-1];
      den_in[k]  = den_q[k-1];
      side_in[k] = side_q[k-1];
    end
  end

  // each stage shifts the next dividend bit into the partial remainder
  always_comb begin
    for (int k = 0; k < N; k++) begin
      trial_w[k] = {rem_in[k], num_in[k][N-1]};
      diff_w[k]  = trial_w[k] - {1'b0, den_in[k]};
      fit_w[k]   = (trial_w[k] >= {1'b0, den_in[k]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < N; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en_i) begin
      for (int k = 0; k < N; k++) begin
        vld_q[k] <= vld_in[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < N; k++) begin
        num_q[k]  <= {num_in[k][N-2:0], fit_w[k]};
        rem_q[k]  <= fit_w[k] ? diff_w[k][D-1:0] : trial_w[k][D-1:0];
        den_q[k]  <= den_in[k];
        side_q[k] <= side_in[k];
      end
    end
  end

  assign vld_o  = vld_q[N-1];
  assign quo_o  = num_q[N-1];
  assign side_o = side_q[N-1];

  // final remainder must be below a nonzero divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[N-1] |-> (den_q[N-1] == '0) || (rem_q[N-1] < den_q[N-1]))
    else $error("divider remainder not reduced below divisor");

  // a held pipeline keeps its last stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(vld_o) && (!vld_o || $stable(quo_o)))
    else $error("divider output moved while stalled");

  // an enabled first stage takes the incoming valid bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i |=> vld_q[0] == $past(vld_i))
    else $error("divider first stage lost its valid bit");

endmodule

`default_nettype wire
